>>> hw/rtl/mss_pkg.sv
package mss_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 12;
	localparam int LIMIT_W = 12;
	localparam int TICKREG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF = 3'd4;

	// Reset values of the configuration registers
	localparam logic [LIMIT_W-1:0] RST_STALL_THR = 12'd1200;
	localparam logic [LIMIT_W-1:0] RST_OVER_LIM = 12'd1600;
	localparam logic [TICKREG_W-1:0] RST_RUN_LIM = 16'd9000;
	localparam logic [TICKREG_W-1:0] RST_BLANK = 16'd350;
	localparam logic [TICKREG_W-1:0] RST_BACKOFF = 16'd150;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN = 2'd1,
		PH_BACKOFF = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DRV_FWD = 2'd0,
		DRV_REV = 2'd1,
		DRV_STBY = 2'd2,
		DRV_BRAKE = 2'd3
	} drive_t;

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_TIMEOUT = 2'd1,
		CAUSE_STALL = 2'd2,
		CAUSE_OVER = 2'd3
	} cause_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] stall_threshold;
		logic [LIMIT_W-1:0] overcurrent_limit;
		logic [TICKREG_W-1:0] run_limit_ticks;
		logic [TICKREG_W-1:0] blank_ticks;
		logic [TICKREG_W-1:0] backoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic req_type;
		logic [1:0] action;
		logic [SAMPLE_W-1:0] current_sample;
	} req_t;

	typedef struct packed {
		logic pin_one;
		logic pin_two;
		logic busy_res;
		logic finished;
		logic [1:0] stop_cause;
	} res_t;

endpackage

>>> hw/rtl/mss_req_if.sv
interface mss_req_if;
	import mss_pkg::*;

	logic valid;
	logic ready;
	logic req_type;
	logic [1:0] action;
	logic [SAMPLE_W-1:0] current_sample;

	modport source (output valid, req_type, action, current_sample, input ready);
	modport sink (input valid, req_type, action, current_sample, output ready);
endinterface

>>> hw/rtl/mss_res_if.sv
interface mss_res_if;
	logic valid;
	logic ready;
	logic pin_one;
	logic pin_two;
	logic busy_res;
	logic finished;
	logic [1:0] stop_cause;

	modport source (output valid, pin_one, pin_two, busy_res, finished, stop_cause,
		input ready);
	modport sink (input valid, pin_one, pin_two, busy_res, finished, stop_cause,
		output ready);
endinterface

>>> hw/rtl/mss_cfg_regs.sv
module mss_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mss_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [mss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output mss_pkg::cfg_t cfg
);
	import mss_pkg::*;

	cfg_t cfg_q;

	// Register file; writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_threshold <= RST_STALL_THR;
			cfg_q.overcurrent_limit <= RST_OVER_LIM;
			cfg_q.run_limit_ticks <= RST_RUN_LIM;
			cfg_q.blank_ticks <= RST_BLANK;
			cfg_q.backoff_ticks <= RST_BACKOFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STALL_THR: cfg_q.stall_threshold <= cfg_wdata[LIMIT_W-1:0];
				CFG_OVER_LIM: cfg_q.overcurrent_limit <= cfg_wdata[LIMIT_W-1:0];
				CFG_RUN_LIM: cfg_q.run_limit_ticks <= cfg_wdata[TICKREG_W-1:0];
				CFG_BLANK: cfg_q.blank_ticks <= cfg_wdata[TICKREG_W-1:0];
				CFG_BACKOFF: cfg_q.backoff_ticks <= cfg_wdata[TICKREG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> hw/rtl/mss_seq_core.sv
module mss_seq_core #(
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_COUNTER_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input mss_pkg::req_t req_s1,
	input mss_pkg::cfg_t cfg,
	output mss_pkg::res_t res_nxt
);
	import mss_pkg::*;

	localparam int TW = TICK_COUNTER_BITS;
	localparam int CW = (TW > TICKREG_W) ? TW : TICKREG_W;
	localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} :
		SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	phase_t phase_q, phase_n;
	drive_t drive_q, drive_n;
	drive_t act_q, act_n;
	cause_t cause_q, cause_n, hit;
	logic [TW-1:0] run_q, run_n, run_inc;
	logic [TW-1:0] bo_q, bo_n, bo_inc;
	logic [SAMPLE_W-1:0] sample;
	logic over_hit, stall_hit, fin;

	// Saturating tick counters and limit compares
	assign sample = req_s1.current_sample & SMASK;
	assign run_inc = (run_q == {TW{1'b1}}) ? run_q : run_q + 1'b1;
	assign bo_inc = (bo_q == {TW{1'b1}}) ? bo_q : bo_q + 1'b1;
	assign over_hit = sample > (cfg.overcurrent_limit & SMASK);
	assign stall_hit = (CW'(run_q) >= CW'(cfg.blank_ticks)) &&
		(sample >= (cfg.stall_threshold & SMASK));

	// Next state for the request in the input register
	always_comb begin
		phase_n = phase_q;
		drive_n = drive_q;
		act_n = act_q;
		cause_n = cause_q;
		run_n = run_q;
		bo_n = bo_q;
		fin = 1'b0;
		hit = CAUSE_NONE;
		if (req_s1.req_type == REQ_START) begin
			if (phase_q == PH_IDLE) begin
				act_n = drive_t'(req_s1.action);
				drive_n = drive_t'(req_s1.action);
				run_n = '0;
				bo_n = '0;
				cause_n = CAUSE_NONE;
				phase_n = PH_RUN;
			end
		end else begin
			case (phase_q)
				PH_RUN: begin
					if (over_hit) begin
						hit = CAUSE_OVER;
					end else if (stall_hit) begin
						hit = CAUSE_STALL;
					end else begin
						run_n = run_inc;
						if (CW'(run_inc) >= CW'(cfg.run_limit_ticks))
							hit = CAUSE_TIMEOUT;
					end
					if (hit != CAUSE_NONE) begin
						cause_n = hit;
						if (hit == CAUSE_OVER)
							drive_n = DRV_BRAKE;
						// reversal swallows the momentary brake
						if (act_q == DRV_FWD)
							drive_n = DRV_REV;
						else if (act_q == DRV_REV)
							drive_n = DRV_FWD;
						bo_n = '0;
						if (cfg.backoff_ticks == '0) begin
							drive_n = DRV_STBY;
							phase_n = PH_IDLE;
							fin = 1'b1;
						end else begin
							phase_n = PH_BACKOFF;
						end
					end
				end
				PH_BACKOFF: begin
					bo_n = bo_inc;
					if (CW'(bo_inc) >= CW'(cfg.backoff_ticks)) begin
						drive_n = DRV_STBY;
						phase_n = PH_IDLE;
						fin = 1'b1;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	// Result fields as seen after this request
	always_comb begin
		res_nxt.pin_one = (drive_n == DRV_REV) || (drive_n == DRV_BRAKE);
		res_nxt.pin_two = (drive_n == DRV_FWD) || (drive_n == DRV_BRAKE);
		res_nxt.busy_res = (phase_n == PH_RUN) || (phase_n == PH_BACKOFF);
		res_nxt.finished = fin;
		res_nxt.stop_cause = cause_n;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			drive_q <= DRV_STBY;
			act_q <= DRV_FWD;
			cause_q <= CAUSE_NONE;
			run_q <= '0;
			bo_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			drive_q <= drive_n;
			act_q <= act_n;
			cause_q <= cause_n;
			run_q <= run_n;
			bo_q <= bo_n;
		end
	end

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fin |=> phase_q == PH_IDLE)
		else $error("finished without returning to idle");
	a_run_no_cause: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RUN |-> cause_q == CAUSE_NONE)
		else $error("stop cause set while still running");
	a_idle_standby: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> drive_q == DRV_STBY)
		else $error("bridge driven while idle");
	a_backoff_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BACKOFF && (act_q == DRV_FWD || act_q == DRV_REV)
		|-> drive_q != act_q && drive_q != DRV_BRAKE && drive_q != DRV_STBY)
		else $error("backoff of a direction run not driving opposite way");
endmodule

>>> hw/rtl/motor_stall_stop_sequencer.sv
// H-bridge run sequencer with stall and overcurrent cutoff. A start request picks
// forward, reverse, standby or brake; each tick request carries one 1 ms current
// sample and yields one result with the pin pair, busy flag, a finished pulse and
// the stop cause. One request is taken every clock cycle while the result register is
// free or being read; its result passes the input register, then the result register.
// The rate is set by the state update, whose compares and saturating counters feed
// straight back for the next request. The user must write configuration through
// cfg_we/cfg_idx/cfg_wdata while no request is in flight; the block does not enforce it.
module motor_stall_stop_sequencer #(
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_COUNTER_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mss_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [mss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mss_req_if.sink req,
	mss_res_if.source res
);
	import mss_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	res_t res_nxt, res_s2;
	logic s1_valid_q, s2_valid_q;
	logic advance;

	mss_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	mss_seq_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TICK_COUNTER_BITS(TICK_COUNTER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.req_s1(req_s1),
		.cfg(cfg),
		.res_nxt(res_nxt)
	);

	// Handshake: the input stage moves on when the result register is free or being read
	assign advance = s1_valid_q && (!s2_valid_q || res.ready);
	assign req.ready = !s1_valid_q || advance;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (req.ready)
				s1_valid_q <= req.valid;
			if (advance)
				s2_valid_q <= 1'b1;
			else if (res.ready)
				s2_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type <= req.req_type;
			req_s1.action <= req.action;
			req_s1.current_sample <= req.current_sample;
		end
		if (advance)
			res_s2 <= res_nxt;
	end

	assign res.valid = s2_valid_q;
	assign res.pin_one = res_s2.pin_one;
	assign res.pin_two = res_s2.pin_two;
	assign res.busy_res = res_s2.busy_res;
	assign res.finished = res_s2.finished;
	assign res.stop_cause = res_s2.stop_cause;
endmodule

>>> bench/mss_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the config port, predicts every result of the
// sequencer and compares accepted results in order.
module mss_checker import mss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	mss_req_if req,
	mss_res_if res,
	output int fail_count,
	output int pending
);

	// Shadow of the block's registers and run state
	cfg_t cfg;
	phase_t seq_phase;
	drive_t seq_drive;
	drive_t seq_act;
	cause_t seq_cause;
	logic [TICKREG_W-1:0] run_ticks;
	logic [TICKREG_W-1:0] back_ticks;

	// Expected results, oldest first
	res_t expected_q[$];

	function automatic logic [TICKREG_W-1:0] sat_inc(input logic [TICKREG_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void enter_standby(output logic fin);
		seq_drive = DRV_STBY;
		seq_phase = PH_IDLE;
		fin = 1'b1;
	endfunction

	// Advance the run state by one request and return the pins and flags after it
	function automatic res_t step_sequencer(input req_t r);
		res_t o;
		cause_t c;
		logic fin;
		fin = 1'b0;
		c = CAUSE_NONE;
		if (r.req_type == REQ_START) begin
			// start only takes effect from idle
			if (seq_phase == PH_IDLE) begin
				seq_act = drive_t'(r.action);
				seq_drive = drive_t'(r.action);
				run_ticks = '0;
				back_ticks = '0;
				seq_cause = CAUSE_NONE;
				seq_phase = PH_RUN;
			end
		end else if (seq_phase == PH_RUN) begin
			// overcurrent beats stall; both checked before the tick counts
			if (r.current_sample > cfg.overcurrent_limit) begin
				c = CAUSE_OVER;
			end else if (run_ticks >= cfg.blank_ticks &&
				r.current_sample >= cfg.stall_threshold) begin
				c = CAUSE_STALL;
			end else begin
				run_ticks = sat_inc(run_ticks);
				if (run_ticks >= cfg.run_limit_ticks) begin
					c = CAUSE_TIMEOUT;
				end
			end
			if (c != CAUSE_NONE) begin
				seq_cause = c;
				if (c == CAUSE_OVER) begin
					seq_drive = DRV_BRAKE;
				end
				// forward/reverse runs back off in the opposite direction
				if (seq_act == DRV_FWD) begin
					seq_drive = DRV_REV;
				end else if (seq_act == DRV_REV) begin
					seq_drive = DRV_FWD;
				end
				back_ticks = '0;
				if (cfg.backoff_ticks == '0) begin
					enter_standby(fin);
				end else begin
					seq_phase = PH_BACKOFF;
				end
			end
		end else if (seq_phase == PH_BACKOFF) begin
			back_ticks = sat_inc(back_ticks);
			if (back_ticks >= cfg.backoff_ticks) begin
				enter_standby(fin);
			end
		end
		o.pin_one = (seq_drive == DRV_REV || seq_drive == DRV_BRAKE);
		o.pin_two = (seq_drive == DRV_FWD || seq_drive == DRV_BRAKE);
		o.busy_res = (seq_phase != PH_IDLE);
		o.finished = fin;
		o.stop_cause = seq_cause;
		return o;
	endfunction

	task automatic note_failure(input string what, input res_t exp_r, input res_t got_r);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t %s: exp one=%b two=%b busy=%b fin=%b cause=%0d, got one=%b two=%b busy=%b fin=%b cause=%0d",
				$realtime, what, exp_r.pin_one, exp_r.pin_two, exp_r.busy_res, exp_r.finished,
				exp_r.stop_cause, got_r.pin_one, got_r.pin_two, got_r.busy_res, got_r.finished,
				got_r.stop_cause);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t exp_r;
		req_t r;
		if (!arst_n) begin
			cfg.stall_threshold = RST_STALL_THR;
			cfg.overcurrent_limit = RST_OVER_LIM;
			cfg.run_limit_ticks = RST_RUN_LIM;
			cfg.blank_ticks = RST_BLANK;
			cfg.backoff_ticks = RST_BACKOFF;
			seq_phase = PH_IDLE;
			seq_drive = DRV_STBY;
			seq_act = DRV_FWD;
			seq_cause = CAUSE_NONE;
			run_ticks = '0;
			back_ticks = '0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare first so a request in the same cycle cannot match itself
			if (res.valid && res.ready) begin
				got = {res.pin_one, res.pin_two, res.busy_res, res.finished, res.stop_cause};
				if (expected_q.size() == 0) begin
					note_failure("unexpected result", '0, got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got.pin_one !== exp_r.pin_one || got.pin_two !== exp_r.pin_two ||
						got.busy_res !== exp_r.busy_res || got.finished !== exp_r.finished ||
						got.stop_cause !== exp_r.stop_cause) begin
						note_failure("result mismatch", exp_r, got);
					end
				end
			end
			// register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_idx)
					CFG_STALL_THR: cfg.stall_threshold = cfg_wdata[LIMIT_W-1:0];
					CFG_OVER_LIM: cfg.overcurrent_limit = cfg_wdata[LIMIT_W-1:0];
					CFG_RUN_LIM: cfg.run_limit_ticks = cfg_wdata[TICKREG_W-1:0];
					CFG_BLANK: cfg.blank_ticks = cfg_wdata[TICKREG_W-1:0];
					CFG_BACKOFF: cfg.backoff_ticks = cfg_wdata[TICKREG_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				r = {req.req_type, req.action, req.current_sample};
				expected_q = {expected_q, step_sequencer(r)};
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> bench/tb_motor_stall_stop_sequencer.sv
`timescale 1ns / 100ps

module tb_motor_stall_stop_sequencer;
	import mss_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int fail_count;
	int pending;

	mss_req_if req_ch();
	mss_res_if res_ch();

	motor_stall_stop_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch)
	);

	mss_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Current thresholds, used to aim samples at the compare edges
	logic [LIMIT_W-1:0] cur_stall;
	logic [LIMIT_W-1:0] cur_over;
	int burst_left = 0;

	// Result side: ready follows a stall mode that is picked at random
	initial begin
		int stall_mode;
		int mode_left;
		int cyc;
		int hold;
		stall_mode = 0;
		mode_left = 0;
		cyc = 0;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(40, 160);
			end
			mode_left--;
			cyc++;
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= (cyc % 7) > 2;
				default: begin
					// long stalls now and then
					if (hold > 0) begin
						res_ch.ready <= 1'b0;
						hold--;
					end else begin
						res_ch.ready <= 1'b1;
						if ($urandom_range(0, 5) == 0) hold = $urandom_range(5, 20);
					end
				end
			endcase
		end
	end

	// Send one request; the sender runs in bursts with idle gaps between them
	task automatic send_request(input logic rt, input logic [1:0] act,
		input logic [SAMPLE_W-1:0] smp);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.action <= act;
		req_ch.current_sample <= smp;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [LIMIT_W-1:0] stall_thr, input logic [LIMIT_W-1:0] over_lim,
		input logic [TICKREG_W-1:0] run_lim, input logic [TICKREG_W-1:0] blank,
		input logic [TICKREG_W-1:0] backoff);
		drain();
		write_reg(CFG_STALL_THR, CFG_DATA_W'(stall_thr));
		write_reg(CFG_OVER_LIM, CFG_DATA_W'(over_lim));
		write_reg(CFG_RUN_LIM, CFG_DATA_W'(run_lim));
		write_reg(CFG_BLANK, CFG_DATA_W'(blank));
		write_reg(CFG_BACKOFF, CFG_DATA_W'(backoff));
		cur_stall = stall_thr;
		cur_over = over_lim;
	endtask

	// Quiet samples so runs can time out, plus hits on both thresholds, extremes and noise
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [LIMIT_W-1:0] lo;
		lo = (cur_stall < cur_over) ? cur_stall : cur_over;
		case ($urandom_range(0, 9))
			0: return SAMPLE_W'($urandom);
			1: return cur_stall;
			2: return cur_stall - 1'b1;
			3: return cur_over;
			4: return cur_over + 1'b1;
			5: return '1;
			6: return '0;
			default: return (lo == '0) ? '0 : SAMPLE_W'($urandom_range(0, lo - 1));
		endcase
	endfunction

	// Runs of start + ticks with random content, plus loose noise requests
	task automatic random_traffic(input int n_items);
		int sent;
		int ticks;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 10) begin
				send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					SAMPLE_W'($urandom));
				sent++;
			end else begin
				send_request(REQ_START, 2'($urandom_range(0, 3)), SAMPLE_W'($urandom));
				sent++;
				ticks = $urandom_range(1, 18);
				repeat (ticks) begin
					if ($urandom_range(0, 19) == 0) begin
						send_request(REQ_START, 2'($urandom_range(0, 3)), SAMPLE_W'($urandom));
					end else begin
						send_request(REQ_TICK, 2'($urandom_range(0, 3)), pick_sample());
					end
					sent++;
				end
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_START;
		req_ch.action = DRV_FWD;
		req_ch.current_sample = '0;
		cur_stall = RST_STALL_THR;
		cur_over = RST_OVER_LIM;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: small limits so each stop cause completes quickly
		load_config(12'd100, 12'd200, 16'd3, 16'd2, 16'd2);
		for (int i = CFG_BACKOFF + 1; i < 2 ** CFG_IDX_W; i++) write_reg(CFG_IDX_W'(i), '1);
		send_request(REQ_TICK, DRV_BRAKE, '1);          // tick while idle
		send_request(REQ_START, DRV_FWD, '0);
		send_request(REQ_START, DRV_REV, '1);           // start while busy
		repeat (3) send_request(REQ_TICK, DRV_FWD, '0); // timeout
		repeat (2) send_request(REQ_TICK, DRV_FWD, '0); // backoff to standby
		send_request(REQ_START, DRV_REV, '0);
		send_request(REQ_TICK, DRV_REV, 12'd201);       // overcurrent, reversal
		repeat (2) send_request(REQ_TICK, DRV_REV, '0);
		send_request(REQ_START, DRV_STBY, '0);
		repeat (2) send_request(REQ_TICK, DRV_STBY, 12'd150); // above stall in blanking
		send_request(REQ_TICK, DRV_STBY, 12'd100);      // stall exactly at threshold
		repeat (2) send_request(REQ_TICK, DRV_STBY, '0);
		send_request(REQ_START, DRV_BRAKE, '0);
		send_request(REQ_TICK, DRV_BRAKE, 12'd200);     // equal to limit: not over
		send_request(REQ_TICK, DRV_BRAKE, 12'd201);
		repeat (2) send_request(REQ_TICK, DRV_BRAKE, '0);
		send_request(REQ_START, DRV_STBY, '0);
		send_request(REQ_TICK, DRV_STBY, '1);           // overcurrent in standby run -> brake
		repeat (2) send_request(REQ_TICK, DRV_STBY, '0);

		// All registers at zero: zero backoff finishes on the stopping tick
		load_config('0, '0, '0, '0, '0);
		send_request(REQ_START, DRV_FWD, '0);
		send_request(REQ_TICK, DRV_FWD, '0);
		send_request(REQ_START, DRV_REV, '0);
		send_request(REQ_TICK, DRV_REV, 12'd5);
		random_traffic(40);

		// Run limit of zero times out on the first tick
		load_config('1, '1, '0, '1, 16'd1);
		send_request(REQ_START, DRV_FWD, '0);
		send_request(REQ_TICK, DRV_FWD, 12'd7);
		send_request(REQ_TICK, DRV_FWD, '0);
		random_traffic(30);

		// Everything at maximum: only the run limit can end a run, and this traffic never reaches it
		load_config('1, '1, '1, '1, '1);
		random_traffic(30);

		load_config(12'd800, 12'd3000, 16'd1, '0, 16'd1);
		random_traffic(60);

		repeat (6) begin
			load_config(LIMIT_W'($urandom), LIMIT_W'($urandom),
				TICKREG_W'($urandom_range(1, 20)), TICKREG_W'($urandom_range(0, 8)),
				TICKREG_W'($urandom_range(0, 6)));
			random_traffic(70);
		end

		load_config(RST_STALL_THR, RST_OVER_LIM, RST_RUN_LIM, RST_BLANK, RST_BACKOFF);
		random_traffic(30);

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("[motor_stall_stop_sequencer] OK");
		end else begin
			$display("[motor_stall_stop_sequencer] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("[motor_stall_stop_sequencer] ERROR");
		$finish;
	end

endmodule
